// File: rtl/u8l9_pkg.sv
package u8l9_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PendN = 3;
  localparam int unsigned CntW  = 2;

  // ISO 8859-15 byte to code point; bytes 0x00..0x7F map to themselves
  function automatic logic [CpW-1:0] latin9(input logic [ByteW-1:0] b);
    logic [CpW-1:0] cp;
    begin
      case (b)
        8'hA4:   cp = 21'h020AC;
        8'hA6:   cp = 21'h00160;
        8'hA8:   cp = 21'h00161;
        8'hB4:   cp = 21'h0017D;
        8'hB8:   cp = 21'h0017E;
        8'hBC:   cp = 21'h00152;
        8'hBD:   cp = 21'h00153;
        8'hBE:   cp = 21'h00178;
        default: cp = {{(CpW-ByteW){1'b0}}, b};
      endcase
      return cp;
    end
  endfunction

endpackage

// File: rtl/utf8_decoder_latin9_fallback.sv
// Byte-stream UTF-8 decoder with ISO 8859-15 fallback. One byte is accepted
// per transaction when in_ready_o is high; each result is one transaction on
// the output side, and run_last_o marks the final result caused by a byte.
// A sequencer drives a single Latin-9 mapper and a single output register, so
// a buffered continuation byte gives no result, a byte that opens a sequence
// or produces one result passes through the tail state, and a byte that
// breaks an open sequence first replays the 1..3 buffered bytes as Latin-9,
// one per cycle while the output is free, and is then taken afresh.
// The output register lets the next byte be accepted while a result waits.
// multibyte_enable is written through multibyte_enable_we_i; the user must
// write it only while idle, the block does not enforce this. It resets to 1.
module utf8_decoder_latin9_fallback import u8l9_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             multibyte_enable_we_i,
  input  logic             multibyte_enable_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] byte_in_i,
  input  logic             stream_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CpW-1:0]   code_point_o,
  output logic             fell_back_o,
  output logic             run_last_o
);

  typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_TAIL} state_e;
  // what the byte itself does once any flush is over
  typedef enum logic [1:0] {T_FRESH, T_PARTIAL, T_LATIN} tail_e;

  state_e           state_q, state_d;
  tail_e            tmode_q, tmode_d;
  logic             en_q, en_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d;
  logic [CntW-1:0]  pcount_q, pcount_d;
  logic [CntW-1:0]  need_q, need_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CpW-1:0]   partial_q, partial_d;
  logic             oval_q, oval_d;
  logic [CpW-1:0]   cp_q, cp_d;
  logic             fb_q, fb_d;
  logic             rl_q, rl_d;

  logic [ByteW-1:0] pend_q [PendN];
  logic             pend_we;
  logic [CntW-1:0]  pend_wa;
  logic [ByteW-1:0] pend_wd;

  logic             accept, slot_free;
  logic [ByteW-1:0] map_in;
  logic [CpW-1:0]   map_cp;
  logic [CntW-1:0]  lead_need, need_dec;
  logic [CpW-1:0]   lead_bits;
  logic             fresh_start, tail_emits, flush_end;

  assign accept    = in_valid_i & in_ready_o;
  assign slot_free = ~oval_q | out_ready_i;
  assign need_dec  = need_q - 2'd1;

  // shared Latin-9 mapper: buffered byte while flushing, else the held byte
  assign map_in = (state_q == S_FLUSH) ? pend_q[idx_q] : byte_q;
  assign map_cp = latin9(map_in);

  // lead byte decode of the held byte
  always_comb begin
    lead_need = 2'd0;
    lead_bits = '0;
    case (byte_q) inside
      8'b110?_????: begin
        lead_need = 2'd1;
        lead_bits = {{(CpW-5){1'b0}}, byte_q[4:0]};
      end
      8'b1110_????: begin
        lead_need = 2'd2;
        lead_bits = {{(CpW-4){1'b0}}, byte_q[3:0]};
      end
      8'b1111_0???: begin
        lead_need = 2'd3;
        lead_bits = {{(CpW-3){1'b0}}, byte_q[2:0]};
      end
      default: begin
        lead_need = 2'd0;
        lead_bits = '0;
      end
    endcase
  end

  assign fresh_start = en_q & ~last_q & (lead_need != 2'd0);
  assign tail_emits  = (tmode_q != T_FRESH) | ~fresh_start;
  assign flush_end   = (idx_q == (pcount_q - 2'd1));

  // sequencer
  always_comb begin
    state_d   = state_q;
    tmode_d   = tmode_q;
    en_d      = multibyte_enable_we_i ? multibyte_enable_i : en_q;
    byte_d    = byte_q;
    last_d    = last_q;
    pcount_d  = pcount_q;
    need_d    = need_q;
    idx_d     = idx_q;
    partial_d = partial_q;
    oval_d    = oval_q & ~out_ready_i;
    cp_d      = cp_q;
    fb_d      = fb_q;
    rl_d      = rl_q;
    pend_we   = 1'b0;
    pend_wa   = pcount_q;
    pend_wd   = byte_in_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          byte_d = byte_in_i;
          last_d = stream_end_i;
          if (pcount_q == 2'd0) begin
            tmode_d = T_FRESH;
            state_d = S_TAIL;
          end else if (byte_in_i[7:6] == 2'b10) begin
            partial_d = {partial_q[CpW-7:0], byte_in_i[5:0]};
            if (need_dec == 2'd0) begin
              pcount_d = '0;
              need_d   = '0;
              tmode_d  = T_PARTIAL;
              state_d  = S_TAIL;
            end else if (stream_end_i || pcount_q == 2'd3) begin
              need_d  = need_dec;
              idx_d   = '0;
              tmode_d = T_LATIN;
              state_d = S_FLUSH;
            end else begin
              // buffer the continuation byte, no result yet
              pend_we  = 1'b1;
              pcount_d = pcount_q + 2'd1;
              need_d   = need_dec;
            end
          end else begin
            idx_d   = '0;
            tmode_d = T_FRESH;
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          oval_d = 1'b1;
          cp_d   = map_cp;
          fb_d   = 1'b1;
          rl_d   = flush_end & ~tail_emits;
          idx_d  = idx_q + 2'd1;
          if (flush_end) begin
            pcount_d  = '0;
            need_d    = '0;
            partial_d = '0;
            idx_d     = '0;
            state_d   = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        case (tmode_q)
          T_PARTIAL: begin
            if (slot_free) begin
              oval_d    = 1'b1;
              cp_d      = partial_q;
              fb_d      = 1'b0;
              rl_d      = 1'b1;
              partial_d = '0;
              state_d   = S_IDLE;
            end
          end
          T_LATIN: begin
            if (slot_free) begin
              oval_d  = 1'b1;
              cp_d    = map_cp;
              fb_d    = 1'b1;
              rl_d    = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            if (byte_q[7] && fresh_start) begin
              // open a new sequence
              pend_we   = 1'b1;
              pend_wa   = '0;
              pend_wd   = byte_q;
              pcount_d  = 2'd1;
              need_d    = lead_need;
              partial_d = lead_bits;
              state_d   = S_IDLE;
            end else if (slot_free) begin
              oval_d  = 1'b1;
              cp_d    = map_cp;
              fb_d    = byte_q[7];
              rl_d    = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tmode_q   <= T_FRESH;
      en_q      <= 1'b1;
      byte_q    <= '0;
      last_q    <= 1'b0;
      pcount_q  <= '0;
      need_q    <= '0;
      idx_q     <= '0;
      partial_q <= '0;
      oval_q    <= 1'b0;
      cp_q      <= '0;
      fb_q      <= 1'b0;
      rl_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      tmode_q   <= tmode_d;
      en_q      <= en_d;
      byte_q    <= byte_d;
      last_q    <= last_d;
      pcount_q  <= pcount_d;
      need_q    <= need_d;
      idx_q     <= idx_d;
      partial_q <= partial_d;
      oval_q    <= oval_d;
      cp_q      <= cp_d;
      fb_q      <= fb_d;
      rl_q      <= rl_d;
    end
  end

  // buffered sequence bytes, lead byte included
  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_q[pend_wa] <= pend_wd;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = oval_q;
  assign code_point_o = cp_q;
  assign fell_back_o  = fb_q;
  assign run_last_o   = rl_q;

  // an open sequence always still needs bytes
  a_open_needs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcount_q != 2'd0) |-> (need_q != 2'd0))
    else $error("open sequence with no bytes needed");

  // a flush only runs over buffered bytes
  a_flush_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> (pcount_q != 2'd0) && (idx_q < pcount_q))
    else $error("flush index outside buffered bytes");

  // a completed sequence has already released its buffer
  a_partial_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL && tmode_q == T_PARTIAL) |-> (pcount_q == 2'd0))
    else $error("buffer still open when emitting decoded value");

  // a decoded (non fallback) value never comes out of a flush
  a_flush_fallback : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && slot_free) |=> out_valid_o && fell_back_o)
    else $error("flushed byte not marked as fallback");

endmodule

// File: tb/utf8_decoder_latin9_fallback_tb.sv
`timescale 1ns / 100ps

import u8l9_pkg::*;

// Tracks the decoder state seen by the input side, predicts the code points
// each accepted byte produces and compares them against the output side.
class codepoint_tracker;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           fb;
    logic           last;
  } cp_item_t;

  cp_item_t expected_cps[$];
  cp_item_t batch[$];

  // shadow decoder state
  logic             mb_en;
  logic [ByteW-1:0] seq_bytes[PendN];
  int unsigned      seq_cnt;
  int unsigned      need_left;
  logic [CpW-1:0]   acc_val;

  int unsigned bytes_seen;
  int unsigned checked;
  int unsigned mismatches;
  int unsigned decoded_multi;
  int unsigned fallbacks;

  function new();
    mb_en         = 1'b1;
    seq_cnt       = 0;
    need_left     = 0;
    acc_val       = '0;
    bytes_seen    = 0;
    checked       = 0;
    mismatches    = 0;
    decoded_multi = 0;
    fallbacks     = 0;
  endfunction

  function logic [CpW-1:0] map_latin9(logic [ByteW-1:0] b);
    logic [CpW-1:0] cp;
    case (b)
      8'hA4:   cp = 21'h020AC;
      8'hA6:   cp = 21'h00160;
      8'hA8:   cp = 21'h00161;
      8'hB4:   cp = 21'h0017D;
      8'hB8:   cp = 21'h0017E;
      8'hBC:   cp = 21'h00152;
      8'hBD:   cp = 21'h00153;
      8'hBE:   cp = 21'h00178;
      default: cp = {{(CpW-ByteW){1'b0}}, b};
    endcase
    return cp;
  endfunction

  function void add_cp(logic [CpW-1:0] cp, logic fb);
    cp_item_t item;
    item.cp   = cp;
    item.fb   = fb;
    item.last = 1'b0;
    batch.push_back(item);
  endfunction

  function void clear_seq();
    seq_cnt   = 0;
    need_left = 0;
    acc_val   = '0;
  endfunction

  // replay buffered bytes as Latin-9
  function void flush_seq();
    for (int i = 0; i < seq_cnt; i++) add_cp(map_latin9(seq_bytes[i]), 1'b1);
    clear_seq();
  endfunction

  // byte seen with no sequence open
  function void start_byte(logic [ByteW-1:0] b, logic eos);
    int unsigned    need;
    logic [CpW-1:0] bits;
    need = 0;
    bits = '0;
    if (!b[7]) begin
      add_cp({{(CpW-ByteW){1'b0}}, b}, 1'b0);
      return;
    end
    if (mb_en) begin
      if (b[7:5] == 3'b110) begin
        need = 1;
        bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        need = 2;
        bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        need = 3;
        bits = {18'd0, b[2:0]};
      end
    end
    // no valid lead, or a lead on the final byte
    if (need == 0 || eos) begin
      add_cp(map_latin9(b), 1'b1);
      return;
    end
    seq_bytes[0] = b;
    seq_cnt      = 1;
    need_left    = need;
    acc_val      = bits;
  endfunction

  // accepted input transaction: queue the code points it causes
  function void note_byte(logic [ByteW-1:0] b, logic eos);
    cp_item_t item;
    batch.delete();
    bytes_seen++;
    if (seq_cnt == 0) begin
      start_byte(b, eos);
    end else if (b[7:6] == 2'b10) begin
      acc_val = {acc_val[CpW-7:0], b[5:0]};
      need_left--;
      if (need_left == 0) begin
        add_cp(acc_val, 1'b0);
        clear_seq();
      end else if (eos || seq_cnt >= PendN) begin
        flush_seq();
        add_cp(map_latin9(b), 1'b1);
      end else begin
        seq_bytes[seq_cnt] = b;
        seq_cnt++;
      end
    end else begin
      // sequence broken: replay it, then take this byte afresh
      flush_seq();
      start_byte(b, eos);
    end
    for (int i = 0; i < batch.size(); i++) begin
      item      = batch[i];
      item.last = (i == batch.size() - 1);
      expected_cps.push_back(item);
    end
  endfunction

  function void report(string what, cp_item_t exp_item, cp_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected cp=%06h fb=%b last=%b, got cp=%06h fb=%b last=%b",
               what, exp_item.cp, exp_item.fb, exp_item.last,
               got.cp, got.fb, got.last);
  endfunction

  // accepted output transaction
  function void check_code_point(logic [CpW-1:0] cp, logic fb, logic last);
    cp_item_t got;
    cp_item_t exp_item;
    got.cp   = cp;
    got.fb   = fb;
    got.last = last;
    checked++;
    if (expected_cps.size() == 0) begin
      exp_item = '0;
      report("(nothing expected)", exp_item, got);
      return;
    end
    exp_item = expected_cps.pop_front();
    if (exp_item.cp != got.cp) report("code_point", exp_item, got);
    else if (exp_item.fb != got.fb) report("fell_back", exp_item, got);
    else if (exp_item.last != got.last) report("run_last", exp_item, got);
    if (!fb && cp > 21'h7F) decoded_multi++;
    if (fb) fallbacks++;
  endfunction

  function int pending();
    return expected_cps.size();
  endfunction

endclass

module utf8_decoder_latin9_fallback_tb;

  localparam int HalfPeriod = 4;
  localparam int WatchLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 56;

  logic             clk_i                 = 1'b0;
  logic             rst_ni                = 1'b0;
  logic             multibyte_enable_we_i = 1'b0;
  logic             multibyte_enable_i    = 1'b0;
  logic             in_valid_i            = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] byte_in_i             = '0;
  logic             stream_end_i          = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i           = 1'b0;
  logic [CpW-1:0]   code_point_o;
  logic             fell_back_o;
  logic             run_last_o;

  codepoint_tracker sb;

  // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both
  int idle_mode  = 0;
  bit hold_go    = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left  = 0;
  int idle_cycles = 0;

  utf8_decoder_latin9_fallback u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .multibyte_enable_we_i(multibyte_enable_we_i),
    .multibyte_enable_i   (multibyte_enable_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .byte_in_i            (byte_in_i),
    .stream_end_i         (stream_end_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .code_point_o         (code_point_o),
    .fell_back_o          (fell_back_o),
    .run_last_o           (run_last_o)
  );

  always begin
    #HalfPeriod clk_i = 1'b1;
    #HalfPeriod clk_i = 1'b0;
  end

  // receiver: random stalls per phase, plus one long hold
  always @(posedge clk_i) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ready_i <= ($urandom_range(99) >= 55);
    end else if (idle_mode == 3) begin
      out_ready_i <= ($urandom_range(99) >= 12);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // outputs are stable at the falling edge; what is seen here is what the
  // next rising edge accepts
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_code_point(code_point_o, fell_back_o, run_last_o);
  end

  // watchdog: cycles without any transaction on either side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 WatchLimit, sb.pending());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // offer one byte; called and returns right after a rising edge
  task automatic send_byte(input logic [ByteW-1:0] b, input logic eos);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 55 : (idle_mode == 3) ? 12 : 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    byte_in_i    <= b;
    stream_end_i <= eos;
    do @(negedge clk_i); while (!in_ready_o);
    sb.note_byte(b, eos);
    @(posedge clk_i);
  endtask

  // stop offering and wait until every expected code point has come out
  task automatic wait_drained(input int tail);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_enable(input logic v);
    wait_drained(8);
    multibyte_enable_we_i <= 1'b1;
    multibyte_enable_i    <= v;
    @(posedge clk_i);
    multibyte_enable_we_i <= 1'b0;
    sb.mb_en = v;
  endtask

  function automatic logic [ByteW-1:0] lead_byte(int len);
    logic [ByteW-1:0] r;
    r = ByteW'($urandom);
    case (len)
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [ByteW-1:0] cont_byte();
    logic [ByteW-1:0] r;
    r = ByteW'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // mostly well-formed sequences with random content, plus noise
  task automatic random_phase(input int n_items);
    int               sent;
    int               kind;
    int               len;
    int               k;
    logic [ByteW-1:0] b;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      b    = ByteW'($urandom);
      if (kind < 30) begin
        send_byte({1'b0, b[6:0]}, $urandom_range(15) == 0);
        sent++;
      end else if (kind < 70) begin
        len = $urandom_range(4, 2);
        send_byte(lead_byte(len), 1'b0);
        for (int i = 1; i < len; i++)
          send_byte(cont_byte(), (i == len - 1) && ($urandom_range(7) == 0));
        sent += len;
      end else if (kind < 82) begin
        // partial sequence, then a breaking byte or a final continuation
        len = $urandom_range(4, 2);
        k   = $urandom_range(len - 2, 0);
        send_byte(lead_byte(len), 1'b0);
        for (int i = 0; i < k; i++) send_byte(cont_byte(), 1'b0);
        sent += k + 1;
        if ($urandom_range(3) == 0) begin
          send_byte(cont_byte(), 1'b1);
        end else begin
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          send_byte(b, $urandom_range(7) == 0);
        end
        sent++;
      end else if (kind < 92) begin
        send_byte({1'b1, b[6:0]}, $urandom_range(15) == 0);
        sent++;
      end else begin
        send_byte(b, $urandom_range(1) == 1);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_enable(1'b1);

    // ASCII extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // two-, three- and four-byte sequences, the last one the largest value
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // sequence broken by ASCII
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b0);
    // stray continuation and invalid lead
    send_byte(8'hA4, 1'b0);
    send_byte(8'hFF, 1'b0);
    // lead byte on the final byte
    send_byte(8'hC3, 1'b1);
    // stream ends mid-sequence
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // sequence completed by the final byte
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b1);
    // lead breaks lead, then the enable drops with the sequence still open
    send_byte(8'hC3, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    write_enable(1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hC3, 1'b0);

    for (int p = 0; p < 8; p++) begin
      write_enable((p % 3 == 2) ? 1'b0 : 1'b1);
      idle_mode = p % 4;
      // long output hold while the sender keeps pushing
      if (p == 4) hold_go = 1'b1;
      random_phase(PhaseItems);
    end

    idle_mode = 0;
    wait_drained(20);
    $display("Covered %0d bytes -> %0d code points (%0d multibyte, %0d Latin-9)",
             sb.bytes_seen, sb.checked, sb.decoded_multi, sb.fallbacks);
    $display("Decoding on and off, sender gaps, output stalls, a %0d-cycle hold; %0d mismatches",
             HoldCycles, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
